/* hdl/hgba_pkg.sv */
// Shared constants for the 3x3 box-average grid step.
`timescale 1ns / 1ps
package hgba_pkg;

  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam int MIN_DIM = 3;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int RES_FIFO_DEPTH = 16;

endpackage

/* hdl/hgba_res_fifo.sv */
// Result queue: up to two writes per cycle, one read per cycle.
`timescale 1ns / 1ps
module hgba_res_fifo #(
  parameter int W     = 37,
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   wr_cnt,
  input  logic [W-1:0]                 wr_data0,
  input  logic [W-1:0]                 wr_data1,
  output logic                         rd_valid,
  input  logic                         rd_ready,
  output logic [W-1:0]                 rd_data,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [AW-1:0] wp_p1;

  assign pop      = rd_valid & rd_ready;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];
  assign level    = cnt_r;
  assign wp_p1    = wp_r + AW'(1);

  always_comb begin
    wp_nxt  = wp_r + AW'(wr_cnt);
    rp_nxt  = pop ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + LW'(wr_cnt) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wp_r] <= wr_data0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wp_p1] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/heat_grid_box_average_step.sv */
// 3x3 box-average grid step: line memories, column-sum window, divide-by-nine pipeline.
// Steps after an item is accepted: read, column sum, window sum, magnitude, reciprocal
// multiply, shift and sign; the result is then queued.
// Throughput: one item per cycle; the result queue takes two results per cycle and
// delivers one, so runs of items with two results (last row, last column) throttle in_tready.
// Reset: position counters to 0,0, grid 3x3, result queue empty; line memories
// are not cleared.
`timescale 1ns / 1ps
module heat_grid_box_average_step
  import hgba_pkg::*;
#(
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_value
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_row, out_col, out_value
  output logic [(($clog2(MAX_ROWS)+$clog2(MAX_COLS)+VALUE_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int VW    = VALUE_WIDTH;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RLW   = $clog2(MAX_ROWS+1);
  localparam int CLW   = $clog2(MAX_COLS+1);
  localparam int RCMPW = (RLW > CFG_W) ? RLW : CFG_W;
  localparam int CCMPW = (CLW > CFG_W) ? CLW : CFG_W;
  localparam int CSW   = VW + 2;
  localparam int SW    = VW + 4;
  localparam int N     = SW;
  localparam int H     = N / 2;
  localparam int QW    = N - 3;
  localparam longint unsigned RECIP64 = ((64'd1 << (N+3)) + 64'd8) / 64'd9;
  localparam logic [N-1:0] RECIP = N'(RECIP64);
  localparam int OUT_DW = ((RW+CW+VW+7)/8)*8;
  localparam int ENT_W  = 1 + VW + CW + RW;
  localparam int NST    = 6;
  localparam int LVW    = $clog2(RES_FIFO_DEPTH+1);

  typedef struct packed {
    logic                 vld;
    logic                 is_int;
    logic                 is_bord;
    logic [RW-1:0]        row;
    logic [CW-1:0]        col;
    logic signed [VW-1:0] cval;
  } tag_t;

  logic [RLW-1:0] rows_r;
  logic [CLW-1:0] cols_r;
  logic [RW-1:0]  rows_m1_r;
  logic [CW-1:0]  cols_m1_r;
  logic [RCMPW-1:0] wr_row_ext;
  logic [CCMPW-1:0] wr_col_ext;
  logic [RLW-1:0] rows_clamp;
  logic [CLW-1:0] cols_clamp;

  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic           wrap_c;
  logic [RLW-1:0] r_inc, r1;
  logic [CLW-1:0] c1;
  logic [RW-1:0]  r0;
  logic [CW-1:0]  c0;
  logic           is_int, is_bord;
  logic           acc;
  logic [1:0]     n_acc;

  logic [LVW-1:0] cred_r, cred_nxt;
  logic           pop;

  logic signed [VW-1:0] older_mem [MAX_COLS];
  logic signed [VW-1:0] prev_mem [MAX_COLS];
  logic signed [VW-1:0] top_rd_r, mid_rd_r;

  tag_t tag_r [1:NST];

  logic signed [CSW-1:0] colsum;
  logic signed [CSW-1:0] cs0_r, cs1_r, cs2_r;
  logic signed [SW-1:0]  sum_r;
  logic [N-1:0]          abs_r;
  logic                  neg_a_r, neg_b_r, neg_c_r;
  logic [H+N-1:0]        pplo_r;
  logic [2*N-H-1:0]      pphi_r;
  logic [2*N-1:0]        prod;
  logic [QW-1:0]         q_r;
  logic [QW-1:0]         vq;

  logic [1:0]       wr_cnt;
  logic [ENT_W-1:0] ent_int, ent_bord, wr_data0, wr_data1, rd_data;
  logic             rd_valid;
  logic [LVW-1:0]   fifo_level;

  // configuration
  always_comb begin
    wr_row_ext = RCMPW'(cfg_wdata);
    wr_col_ext = CCMPW'(cfg_wdata);
    if (wr_row_ext < RCMPW'(MIN_DIM)) begin
      rows_clamp = RLW'(MIN_DIM);
    end else if (wr_row_ext > RCMPW'(MAX_ROWS)) begin
      rows_clamp = RLW'(MAX_ROWS);
    end else begin
      rows_clamp = RLW'(wr_row_ext);
    end
    if (wr_col_ext < CCMPW'(MIN_DIM)) begin
      cols_clamp = CLW'(MIN_DIM);
    end else if (wr_col_ext > CCMPW'(MAX_COLS)) begin
      cols_clamp = CLW'(MAX_COLS);
    end else begin
      cols_clamp = CLW'(wr_col_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= RLW'(MIN_DIM);
      cols_r    <= CLW'(MIN_DIM);
      rows_m1_r <= RW'(MIN_DIM - 1);
      cols_m1_r <= CW'(MIN_DIM - 1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_ROWS: begin
          rows_r    <= rows_clamp;
          rows_m1_r <= RW'(rows_clamp - RLW'(1));
        end
        REG_GRID_COLS: begin
          cols_r    <= cols_clamp;
          cols_m1_r <= CW'(cols_clamp - CLW'(1));
        end
        default: begin
        end
      endcase
    end
  end

  // position of the arriving item and the next one
  always_comb begin
    wrap_c  = CLW'(col_r) >= cols_r;
    c0      = wrap_c ? '0 : col_r;
    r_inc   = RLW'(row_r) + RLW'(wrap_c);
    r0      = (r_inc < rows_r) ? RW'(r_inc) : '0;
    c1      = CLW'(c0) + CLW'(1);
    r1      = RLW'(r0) + RLW'(1);
    if (c1 >= cols_r) begin
      col_nxt = '0;
      row_nxt = (r1 >= rows_r) ? '0 : RW'(r1);
    end else begin
      col_nxt = CW'(c1);
      row_nxt = r0;
    end
    is_int  = (r0 >= RW'(2)) && (c0 >= CW'(2));
    is_bord = (r0 == '0) || (r0 == rows_m1_r) || (c0 == '0) || (c0 == cols_m1_r);
    n_acc   = {1'b0, is_int} + {1'b0, is_bord};
  end

  // credits for result queue space
  assign acc       = in_tvalid & in_tready;
  assign pop       = out_tvalid & out_tready;
  assign in_tready = (cred_r <= LVW'(RES_FIFO_DEPTH - 2));

  always_comb begin
    cred_nxt = cred_r + (acc ? LVW'(n_acc) : '0) - LVW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      cred_r <= '0;
    end else begin
      cred_r <= cred_nxt;
      if (acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  // line memories
  always_ff @(posedge clk) begin
    if (acc) begin
      top_rd_r <= older_mem[c0];
    end
    if (tag_r[1].vld) begin
      older_mem[tag_r[1].col] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mid_rd_r <= prev_mem[c0];
    end
    if (tag_r[1].vld) begin
      prev_mem[tag_r[1].col] <= tag_r[1].cval;
    end
  end

  // item tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NST; i++) begin
        tag_r[i].vld <= 1'b0;
      end
    end else begin
      tag_r[1].vld     <= acc;
      tag_r[1].is_int  <= is_int;
      tag_r[1].is_bord <= is_bord;
      tag_r[1].row     <= r0;
      tag_r[1].col     <= c0;
      tag_r[1].cval    <= VW'(in_tdata[VW-1:0]);
      for (int i = 2; i <= NST; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  // window of column sums and divide-by-nine pipeline
  assign colsum = CSW'(top_rd_r) + CSW'(mid_rd_r) + CSW'(tag_r[1].cval);

  always_ff @(posedge clk) begin
    if (tag_r[1].vld) begin
      cs0_r <= cs1_r;
      cs1_r <= cs2_r;
      cs2_r <= colsum;
    end
    sum_r   <= SW'(cs0_r) + SW'(cs1_r) + SW'(cs2_r);
    neg_a_r <= sum_r[SW-1];
    abs_r   <= sum_r[SW-1] ? N'(-sum_r) : N'(sum_r);
    neg_b_r <= neg_a_r;
    pplo_r  <= (H+N)'(abs_r[H-1:0]) * (H+N)'(RECIP);
    pphi_r  <= (2*N-H)'(abs_r[N-1:H]) * (2*N-H)'(RECIP);
    neg_c_r <= neg_b_r;
    q_r     <= prod[2*N-1:N+3];
  end

  assign prod = ((2*N)'(pphi_r) << H) + (2*N)'(pplo_r);
  assign vq   = neg_c_r ? (~q_r + QW'(1)) : q_r;

  // results into the queue
  always_comb begin
    ent_int  = {~tag_r[NST].is_bord, vq[VW-1:0], tag_r[NST].col - CW'(1),
                tag_r[NST].row - RW'(1)};
    ent_bord = {1'b1, tag_r[NST].cval, tag_r[NST].col, tag_r[NST].row};
    wr_data0 = tag_r[NST].is_int ? ent_int : ent_bord;
    wr_data1 = ent_bord;
    if (tag_r[NST].vld) begin
      wr_cnt = {1'b0, tag_r[NST].is_int} + {1'b0, tag_r[NST].is_bord};
    end else begin
      wr_cnt = 2'd0;
    end
  end

  hgba_res_fifo #(
    .W     (ENT_W),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr_data0 (wr_data0),
    .wr_data1 (wr_data1),
    .rd_valid (rd_valid),
    .rd_ready (out_tready),
    .rd_data  (rd_data),
    .level    (fifo_level)
  );

  assign out_tvalid = rd_valid & (fifo_level != '0);
  assign out_tdata  = OUT_DW'(rd_data[ENT_W-2:0]);
  assign out_tlast  = rd_data[ENT_W-1];

endmodule
